### rtl/core/sno_pkg.sv
// sno_pkg: shared constants and types of the sector nearest obstacle unit
// angle and range limits, zone codes, configuration register indexes
// no dependencies
`timescale 1ns / 1ps

package sno_pkg;

	localparam int ZoneCount = 6;

	typedef logic [15:0] angle_t;
	typedef logic [15:0] range_t;
	typedef logic [2:0]  zone_t;
	typedef logic [1:0]  cfg_index_t;
	typedef logic [15:0] cfg_data_t;

	// configuration register indexes
	localparam cfg_index_t CFG_HEADING_OFFSET = 2'd0;
	localparam cfg_index_t CFG_REVERSE_ANGLE  = 2'd1;
	localparam cfg_index_t CFG_NEAR_CUTOFF    = 2'd2;
	localparam cfg_index_t CFG_FAR_CLAMP      = 2'd3;

	// zone codes
	localparam zone_t ZONE_FRONT       = 3'd0;
	localparam zone_t ZONE_FRONT_RIGHT = 3'd1;
	localparam zone_t ZONE_REAR_RIGHT  = 3'd2;
	localparam zone_t ZONE_REAR        = 3'd3;
	localparam zone_t ZONE_REAR_LEFT   = 3'd4;
	localparam zone_t ZONE_FRONT_LEFT  = 3'd5;

	// full turn in hundredths of a degree
	localparam angle_t FULL_TURN = 16'd36000;

	// upper edges of the zones; a boundary angle belongs to the lower zone, but EDGE_FRONT_LEFT belongs to the front
	localparam angle_t EDGE_FRONT       = 16'd3000;
	localparam angle_t EDGE_FRONT_RIGHT = 16'd9000;
	localparam angle_t EDGE_REAR_RIGHT  = 16'd15000;
	localparam angle_t EDGE_REAR        = 16'd21000;
	localparam angle_t EDGE_REAR_LEFT   = 16'd27000;
	localparam angle_t EDGE_FRONT_LEFT  = 16'd33000;

	// register reset values
	localparam angle_t RESET_HEADING_OFFSET = 16'd0;
	localparam range_t RESET_NEAR_CUTOFF    = 16'd20;
	localparam range_t RESET_FAR_CLAMP      = 16'd500;

endpackage

### rtl/core/sno_if.sv
// sno_point_if and sno_minima_if: valid/ready channels of the unit
// depends on sno_pkg for the payload types
`timescale 1ns / 1ps

interface sno_point_if import sno_pkg::*; ();
	logic   valid;
	logic   ready;
	angle_t beam_angle;
	range_t range_mm;
	logic   end_of_turn;

	modport source (output valid, beam_angle, range_mm, end_of_turn, input ready);
	modport sink   (input valid, beam_angle, range_mm, end_of_turn, output ready);
endinterface

interface sno_minima_if import sno_pkg::*; ();
	logic   valid;
	logic   ready;
	range_t near_front;
	range_t near_front_right;
	range_t near_rear_right;
	range_t near_rear;
	range_t near_rear_left;
	range_t near_front_left;

	modport source (output valid, near_front, near_front_right, near_rear_right,
		near_rear, near_rear_left, near_front_left, input ready);
	modport sink   (input valid, near_front, near_front_right, near_rear_right,
		near_rear, near_rear_left, near_front_left, output ready);
endinterface

### rtl/core/sno_zone_map.sv
// sno_zone_map: beam angle to robot angle and zone code, combinational
// depends on sno_pkg
`timescale 1ns / 1ps

module sno_zone_map import sno_pkg::*; (
	input  angle_t beam_angle,
	input  angle_t heading_offset,
	input  logic   reverse_angle,
	output zone_t  zone
);

	angle_t      beam_red;
	angle_t      offset_red;
	logic [16:0] diff;
	angle_t      turned;
	angle_t      body_angle;

	always_comb begin
		// inputs are below twice a full turn, so one subtract reduces them
		beam_red   = (beam_angle >= FULL_TURN) ? beam_angle - FULL_TURN : beam_angle;
		offset_red = (heading_offset >= FULL_TURN) ? heading_offset - FULL_TURN
			: heading_offset;
		diff = {1'b0, beam_red} - {1'b0, offset_red};
		// wrap a negative difference back into one turn
		turned = diff[16] ? diff[15:0] + FULL_TURN : diff[15:0];
		if (reverse_angle && (turned != '0)) begin
			body_angle = FULL_TURN - turned;
		end else begin
			body_angle = turned;
		end

		if (body_angle <= EDGE_FRONT) begin
			zone = ZONE_FRONT;
		end else if (body_angle <= EDGE_FRONT_RIGHT) begin
			zone = ZONE_FRONT_RIGHT;
		end else if (body_angle <= EDGE_REAR_RIGHT) begin
			zone = ZONE_REAR_RIGHT;
		end else if (body_angle <= EDGE_REAR) begin
			zone = ZONE_REAR;
		end else if (body_angle <= EDGE_REAR_LEFT) begin
			zone = ZONE_REAR_LEFT;
		end else if (body_angle < EDGE_FRONT_LEFT) begin
			zone = ZONE_FRONT_LEFT;
		end else begin
			// the front zone wraps through zero
			zone = ZONE_FRONT;
		end
	end

endmodule

### rtl/core/sector_nearest_obstacle_unit.sv
// sector_nearest_obstacle_unit: top level of the six-zone nearest obstacle unit
// depends on sno_pkg, sno_point_if, sno_minima_if and sno_zone_map
`timescale 1ns / 1ps

// One lidar point enters per item on the point channel and one item can be
// accepted every clock cycle while the input is not stalled. An accepted point
// is held in an input register; in the following cycle its angle is offset,
// optionally mirrored and binned into one of six 60 degree zones, its range is
// checked against the near cutoff and far clamp, and the zone minimum is
// updated. On a point marked as the end of a turn, the six minima (including
// that point) are loaded into the result register and shown on the minima
// channel, and every zone is refilled with the far clamp. A waiting result
// stalls the input only when another end-of-turn point reaches it. After reset
// all zones read 500 mm. Configuration is written through cfg_en, cfg_index and
// cfg_data and should change only while no point is in flight.

module sector_nearest_obstacle_unit import sno_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_en,
	input  cfg_index_t   cfg_index,
	input  cfg_data_t    cfg_data,
	sno_point_if.sink    point,
	sno_minima_if.source minima
);

	// configuration registers
	angle_t heading_offset_q;
	logic   reverse_angle_q;
	range_t near_cutoff_q;
	range_t far_clamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_offset_q <= RESET_HEADING_OFFSET;
			reverse_angle_q  <= 1'b0;
			near_cutoff_q    <= RESET_NEAR_CUTOFF;
			far_clamp_q      <= RESET_FAR_CLAMP;
		end else if (cfg_en) begin
			case (cfg_index)
				CFG_HEADING_OFFSET: heading_offset_q <= cfg_data;
				CFG_REVERSE_ANGLE:  reverse_angle_q  <= cfg_data[0];
				CFG_NEAR_CUTOFF:    near_cutoff_q    <= cfg_data;
				CFG_FAR_CLAMP:      far_clamp_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register stage
	logic   valid_s1;
	angle_t beam_s1;
	range_t range_s1;
	logic   last_s1;
	logic   advance_s1;
	logic   out_valid_q;

	// the stage moves on unless it must emit while the result register is full and not taken
	assign advance_s1  = valid_s1 && (!last_s1 || !out_valid_q || minima.ready);
	assign point.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (point.ready) begin
			valid_s1 <= point.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (point.valid && point.ready) begin
			beam_s1  <= point.beam_angle;
			range_s1 <= point.range_mm;
			last_s1  <= point.end_of_turn;
		end
	end

	// zone of the held point
	zone_t zone_s1;

	sno_zone_map u_zone_map (
		.beam_angle     (beam_s1),
		.heading_offset (heading_offset_q),
		.reverse_angle  (reverse_angle_q),
		.zone           (zone_s1)
	);

	// range filter, both limits inclusive
	logic keep_s1;
	assign keep_s1 = (range_s1 >= near_cutoff_q) && (range_s1 <= far_clamp_q);

	// one lane per zone: each minimum is compared only against the held range
	range_t zone_min_q [ZoneCount];
	range_t zone_next  [ZoneCount];

	always_comb begin
		for (int z = 0; z < ZoneCount; z++) begin
			if (keep_s1 && (zone_s1 == zone_t'(z)) && (range_s1 < zone_min_q[z])) begin
				zone_next[z] = range_s1;
			end else begin
				zone_next[z] = zone_min_q[z];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int z = 0; z < ZoneCount; z++) begin
				zone_min_q[z] <= RESET_FAR_CLAMP;
			end
		end else if (advance_s1) begin
			for (int z = 0; z < ZoneCount; z++) begin
				// refill at the end of a turn with the current far clamp
				zone_min_q[z] <= last_s1 ? far_clamp_q : zone_next[z];
			end
		end
	end

	// result register
	range_t result_q [ZoneCount];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (minima.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			for (int z = 0; z < ZoneCount; z++) begin
				result_q[z] <= zone_next[z];
			end
		end
	end

	assign minima.valid            = out_valid_q;
	assign minima.near_front       = result_q[ZONE_FRONT];
	assign minima.near_front_right = result_q[ZONE_FRONT_RIGHT];
	assign minima.near_rear_right  = result_q[ZONE_REAR_RIGHT];
	assign minima.near_rear        = result_q[ZONE_REAR];
	assign minima.near_rear_left   = result_q[ZONE_REAR_LEFT];
	assign minima.near_front_left  = result_q[ZONE_FRONT_LEFT];

endmodule
